// File: hdl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

  // Width of the hold time accumulator.
  localparam int HOLD_BITS = 16;
  localparam int SUM_W = HOLD_BITS + 1;
  localparam int THRESH_W = 16;
  localparam int CMP_W = (HOLD_BITS > THRESH_W) ? HOLD_BITS : THRESH_W;

  localparam int PERIOD_W = 10;
  localparam int LATE_W = 10;
  localparam int STATUS_W = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME = 2'd2;

  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 10'd50;
  localparam logic [THRESH_W-1:0] RST_CLICK_TIME = 16'd200;
  localparam logic [THRESH_W-1:0] RST_LONG_TIME = 16'd3000;

  // Item operations.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LISTEN = 1'b1;

  // Press status codes.
  localparam logic [STATUS_W-1:0] ST_NONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLICK_PRESS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLICK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONG_PRESS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LONG_LISTEN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LONG_REL = 3'd5;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period;
    logic [THRESH_W-1:0] click_time;
    logic [THRESH_W-1:0] long_time;
  } cfg_t;

  typedef struct packed {
    logic                operation;
    logic                pressed;
    logic [LATE_W-1:0]   late_ms;
    logic [STATUS_W-1:0] query_state;
  } item_t;

endpackage
`default_nettype wire

// File: hdl/bpc_in_if.sv
`default_nettype none
interface bpc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic                              pressed;
  logic [bpc_pkg::LATE_W-1:0]        late_ms;
  logic [bpc_pkg::STATUS_W-1:0]      query_state;

  modport source (output valid, output operation, output pressed, output late_ms,
                  output query_state, input ready);
  modport sink (input valid, input operation, input pressed, input late_ms,
                input query_state, output ready);
endinterface
`default_nettype wire

// File: hdl/bpc_out_if.sv
`default_nettype none
interface bpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpc_pkg::STATUS_W-1:0] status;
  logic                         matched;

  modport source (output valid, output status, output matched, input ready);
  modport sink (input valid, input status, input matched, output ready);
endinterface
`default_nettype wire

// File: hdl/bpc_cfg_regs.sv
`default_nettype none
module bpc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bpc_pkg::cfg_t                           cfg
);

  bpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period <= bpc_pkg::RST_SAMPLE_PERIOD;
      cfg_r.click_time <= bpc_pkg::RST_CLICK_TIME;
      cfg_r.long_time <= bpc_pkg::RST_LONG_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_SAMPLE_PERIOD:
          cfg_r.sample_period <= cfg_wdata[bpc_pkg::PERIOD_W-1:0];
        bpc_pkg::CFG_CLICK_TIME:
          cfg_r.click_time <= cfg_wdata[bpc_pkg::THRESH_W-1:0];
        bpc_pkg::CFG_LONG_TIME:
          cfg_r.long_time <= cfg_wdata[bpc_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: hdl/bpc_classify.sv
`default_nettype none
module bpc_classify (
  input  wire bpc_pkg::cfg_t                     cfg,
  input  wire bpc_pkg::item_t                    item,
  input  wire logic [bpc_pkg::HOLD_BITS-1:0]     hold,
  input  wire logic [bpc_pkg::STATUS_W-1:0]      status,
  output logic [bpc_pkg::HOLD_BITS-1:0]          hold_nxt,
  output logic [bpc_pkg::STATUS_W-1:0]           status_nxt,
  output logic                                   matched
);

  logic [bpc_pkg::SUM_W-1:0]     sum;
  logic [bpc_pkg::HOLD_BITS-1:0] hold_smp;
  logic [bpc_pkg::CMP_W-1:0]     hold_cmp;
  logic [bpc_pkg::CMP_W-1:0]     click_cmp;
  logic [bpc_pkg::CMP_W-1:0]     long_cmp;
  logic [bpc_pkg::STATUS_W-1:0]  status_smp;

  // The top bit of the sum flags an overflow, which saturates the hold time.
  assign sum = {1'b0, hold} + bpc_pkg::SUM_W'(cfg.sample_period)
             + bpc_pkg::SUM_W'(item.late_ms);

  always_comb begin
    if (!item.pressed) begin
      hold_smp = '0;
    end else if (sum[bpc_pkg::HOLD_BITS]) begin
      hold_smp = '1;
    end else begin
      hold_smp = sum[bpc_pkg::HOLD_BITS-1:0];
    end
  end

  assign hold_cmp = bpc_pkg::CMP_W'(hold_smp);
  assign click_cmp = bpc_pkg::CMP_W'(cfg.click_time);
  assign long_cmp = bpc_pkg::CMP_W'(cfg.long_time);

  always_comb begin
    status_smp = status;
    if (hold_cmp >= click_cmp && hold_cmp < long_cmp) begin
      status_smp = bpc_pkg::ST_CLICK_PRESS;
    end else if (status != bpc_pkg::ST_LONG_LISTEN && hold_cmp >= long_cmp) begin
      status_smp = bpc_pkg::ST_LONG_PRESS;
    end else if (hold_smp == '0) begin
      if (status == bpc_pkg::ST_CLICK_PRESS) begin
        status_smp = bpc_pkg::ST_CLICK;
      end else if (status == bpc_pkg::ST_LONG_PRESS ||
                   status == bpc_pkg::ST_LONG_LISTEN) begin
        status_smp = bpc_pkg::ST_LONG_REL;
      end
    end
  end

  always_comb begin
    hold_nxt = hold;
    status_nxt = status;
    matched = 1'b0;
    if (item.operation == bpc_pkg::OP_SAMPLE) begin
      hold_nxt = hold_smp;
      status_nxt = status_smp;
    end else if (item.query_state == status) begin
      // A long press that has been listened for is not reported again.
      matched = 1'b1;
      if (status == bpc_pkg::ST_LONG_PRESS) begin
        status_nxt = bpc_pkg::ST_LONG_LISTEN;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/button_press_classifier.sv
// Push-button classifier: turns sampled button levels into click and
// long-press status codes.
// Input channel in_ch: a sample item (operation 0) carries the button level
// and how many ms late it came; a listen item (operation 1) asks whether the
// status equals query_state. Every item produces exactly one result on
// out_ch: the status after the item and, for a listen item, the match flag.
// The user writes the configuration (sample period, click time, long time)
// via cfg_we/cfg_index/cfg_wdata only with no item in flight; not enforced.
// The input register feeds the classify logic, which loads the result register
// when the result register is free or being drained. Throughput is one item
// per cycle while out_ch does not stall, set by the combinational hold-time
// add and threshold compare that feed the state registers.
// When out_ch stalls, the result register holds, the input register fills,
// and in_ch.ready drops only once both are occupied.
// Synchronous active-low reset clears the hold time, sets the status to
// none, loads the configuration defaults (50, 200, 3000 ms) and empties both
// registers.
`default_nettype none
module button_press_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bpc_in_if.sink                              in_ch,
  bpc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bpc_pkg::cfg_t                 cfg;
  bpc_pkg::item_t                s1_item_r;
  logic                          s1_valid_r;
  logic                          s1_fire;
  logic                          out_valid_r;
  logic [bpc_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_matched_r;
  logic [bpc_pkg::HOLD_BITS-1:0] hold_r;
  logic [bpc_pkg::HOLD_BITS-1:0] hold_nxt;
  logic [bpc_pkg::STATUS_W-1:0]  status_r;
  logic [bpc_pkg::STATUS_W-1:0]  status_nxt;
  logic                          matched_nxt;
  logic                          in_fire;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_classify u_classify (
    .cfg        (cfg),
    .item       (s1_item_r),
    .hold       (hold_r),
    .status     (status_r),
    .hold_nxt   (hold_nxt),
    .status_nxt (status_nxt),
    .matched    (matched_nxt)
  );

  // The input register moves on whenever the result register is free or is
  // being drained this cycle.
  assign s1_fire = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.operation <= in_ch.operation;
      s1_item_r.pressed <= in_ch.pressed;
      s1_item_r.late_ms <= in_ch.late_ms;
      s1_item_r.query_state <= in_ch.query_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      status_r <= bpc_pkg::ST_NONE;
    end else if (s1_fire) begin
      hold_r <= hold_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r <= status_nxt;
      out_matched_r <= matched_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.matched = out_matched_r;

  a_listen_keeps_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.operation == bpc_pkg::OP_LISTEN |=> $stable(hold_r))
    else $error("listen item changed the hold time");

  a_release_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.operation == bpc_pkg::OP_SAMPLE && !s1_item_r.pressed
    |=> hold_r == '0)
    else $error("released sample left a nonzero hold time");

  a_listened_from_long: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status_r == bpc_pkg::ST_LONG_LISTEN) |-> $past(status_r) == bpc_pkg::ST_LONG_PRESS)
    else $error("listened status entered from other than long press");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled while the pipeline could move");

endmodule
`default_nettype wire
